FILE: design/clas_pkg.sv
// shared types and constants for the command-line argument splitter
package clas_pkg;

  localparam int unsigned LineChars = 2048;
  localparam int unsigned CountCap  = (LineChars < 4095) ? LineChars : 4095;

  localparam logic [15:0] ChQuote = 16'h0022;
  localparam logic [15:0] ChSlash = 16'h005C;
  localparam logic [15:0] ChBlank = 16'h0020;
  localparam logic [15:0] ChTab   = 16'h0009;
  localparam logic [11:0] CapVal  = 12'(CountCap);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_FIRST = 2'd1,
    PH_GAP   = 2'd2,
    PH_LATER = 2'd3
  } phase_e;

  typedef struct packed {
    logic [15:0] out_char;
    logic [11:0] run_length;
    logic        arg_end;
    logic [11:0] arg_count;
    logic        last_result;
  } res_t;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  quote_cnt;
    logic        quote_open;
    logic [11:0] slash_cnt;
    logic [11:0] args_done;
  } pstate_t;

  // up to two result words handed from the parser to the result queue
  typedef struct packed {
    logic [1:0]      n;
    res_t [1:0]      res;
  } push_t;

endpackage

FILE: design/clas_parse.sv
// input register, parse state and per-character split logic
module clas_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        char_code_i,
  input  logic               last_char_i,
  input  logic               space_i,
  output clas_pkg::push_t    push_o
);
  import clas_pkg::*;

  typedef struct packed {
    pstate_t st;
    push_t   pu;
  } work_t;

  logic        in_vld_q;
  logic [15:0] char_q;
  logic        last_q;
  pstate_t     st_q, st_d;
  logic        proc;
  work_t       w;

  // append a run of len copies of ch
  function automatic work_t put_run(work_t wi, logic [15:0] ch, logic [11:0] len);
    work_t wo;
    wo = wi;
    if (len != 12'd0 && wo.pu.n != 2'd2) begin
      wo.pu.res[wo.pu.n[0]] = '{out_char: ch, run_length: len, arg_end: 1'b0,
                                arg_count: wo.st.args_done, last_result: 1'b0};
      wo.pu.n = wo.pu.n + 2'd1;
    end
    return wo;
  endfunction

  // append a word that carries no characters
  function automatic work_t put_empty(work_t wi);
    work_t wo;
    wo = wi;
    if (wo.pu.n != 2'd2) begin
      wo.pu.res[wo.pu.n[0]] = '{out_char: 16'd0, run_length: 12'd0, arg_end: 1'b0,
                                arg_count: wo.st.args_done, last_result: 1'b0};
      wo.pu.n = wo.pu.n + 2'd1;
    end
    return wo;
  endfunction

  // end the current argument on the latest word
  function automatic work_t close_arg(work_t wi);
    work_t wo;
    wo = wi;
    if (wo.st.args_done < CapVal) wo.st.args_done = wo.st.args_done + 12'd1;
    if (wo.pu.n == 2'd0) wo = put_empty(wo);
    wo.pu.res[wo.pu.n[1]].arg_end   = 1'b1;
    wo.pu.res[wo.pu.n[1]].arg_count = wo.st.args_done;
    wo.st.quote_cnt  = 2'd0;
    wo.st.quote_open = 1'b0;
    wo.st.slash_cnt  = 12'd0;
    wo.st.phase      = PH_GAP;
    return wo;
  endfunction

  // one character of a later argument: backslash and quote rules
  function automatic work_t later_char(work_t wi, logic [15:0] c);
    work_t      wo;
    logic       blank;
    logic [2:0] qn;
    wo    = wi;
    blank = (c == ChBlank) || (c == ChTab);
    qn    = 3'd0;
    if (wo.st.quote_open && c != ChQuote) begin
      if (wo.st.quote_cnt == 2'd2) wo.st.quote_cnt = 2'd0;
      wo.st.quote_open = 1'b0;
    end
    if (blank && wo.st.quote_cnt == 2'd0) begin
      wo = put_run(wo, ChSlash, wo.st.slash_cnt);
      wo = close_arg(wo);
    end else if (c == ChSlash) begin
      if (wo.st.slash_cnt < CapVal) wo.st.slash_cnt = wo.st.slash_cnt + 12'd1;
    end else if (c == ChQuote) begin
      if (wo.st.quote_open) begin
        qn = {1'b0, wo.st.quote_cnt} + 3'd1;
        if (qn >= 3'd3) begin
          wo = put_run(wo, ChQuote, 12'd1);
          wo.st.quote_cnt = 2'd0;
        end else begin
          wo.st.quote_cnt = qn[1:0];
        end
      end else begin
        wo = put_run(wo, ChSlash, wo.st.slash_cnt >> 1);
        if (wo.st.slash_cnt[0]) wo = put_run(wo, ChQuote, 12'd1);
        else wo.st.quote_cnt = wo.st.quote_cnt + 2'd1;
        wo.st.slash_cnt  = 12'd0;
        wo.st.quote_open = 1'b1;
      end
    end else begin
      wo = put_run(wo, ChSlash, wo.st.slash_cnt);
      wo.st.slash_cnt = 12'd0;
      wo = put_run(wo, c, 12'd1);
    end
    return wo;
  endfunction

  // input register handshake
  assign proc       = in_vld_q && space_i;
  assign in_stall_o = in_vld_q && !space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  // split logic for the registered character
  always_comb begin
    logic blank;
    blank    = (char_q == ChBlank) || (char_q == ChTab);
    w.st     = st_q;
    w.pu.n   = 2'd0;
    w.pu.res = '0;
    unique case (st_q.phase)
      PH_START: begin
        if (char_q == ChQuote) begin
          w.st.phase     = PH_FIRST;
          w.st.quote_cnt = 2'd1;
        end else if (blank) begin
          w = close_arg(w);
        end else begin
          w.st.phase     = PH_FIRST;
          w.st.quote_cnt = 2'd0;
          w = put_run(w, char_q, 12'd1);
        end
      end
      PH_FIRST: begin
        if (st_q.quote_cnt != 2'd0) begin
          if (char_q == ChQuote) w = close_arg(w);
          else w = put_run(w, char_q, 12'd1);
        end else begin
          if (blank) w = close_arg(w);
          else w = put_run(w, char_q, 12'd1);
        end
      end
      PH_GAP: begin
        if (!blank) begin
          w.st.phase      = PH_LATER;
          w.st.quote_cnt  = 2'd0;
          w.st.quote_open = 1'b0;
          w.st.slash_cnt  = 12'd0;
          w = later_char(w, char_q);
        end
      end
      PH_LATER: begin
        w = later_char(w, char_q);
      end
      default: begin
        w.st = st_q;
      end
    endcase
    // end of line: flush, close and mark the final word
    if (last_q) begin
      if (w.st.phase == PH_LATER) w = put_run(w, ChSlash, w.st.slash_cnt);
      if (w.st.phase == PH_FIRST || w.st.phase == PH_LATER) w = close_arg(w);
      if (w.pu.n == 2'd0) w = put_empty(w);
      w.pu.res[w.pu.n[1]].last_result = 1'b1;
      w.st = '{phase: PH_START, quote_cnt: 2'd0, quote_open: 1'b0,
               slash_cnt: 12'd0, args_done: 12'd0};
    end
    st_d = proc ? w.st : st_q;
    push_o.res = w.pu.res;
    push_o.n   = proc ? w.pu.n : 2'd0;
  end

  // parse state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_START, quote_cnt: 2'd0, quote_open: 1'b0,
                slash_cnt: 12'd0, args_done: 12'd0};
    end else begin
      st_q <= st_d;
    end
  end

endmodule

FILE: design/clas_resq.sv
// four-entry result queue: up to two words in, one word out per cycle unless the output is stalled
module clas_resq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clas_pkg::push_t push_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output clas_pkg::res_t  res_o
);
  import clas_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = cnt_q != 3'd0;
  assign pop         = out_valid_o && !out_stall_i;
  assign space_o     = cnt_q <= 3'd2;
  assign res_o       = mem_q[rp_q];
  assign cnt_d       = cnt_q + {1'b0, push_i.n} - {2'b00, pop};

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wp_q] <= push_i.res[0];
    if (push_i.n == 2'd2) mem_q[wp_q + 2'd1] <= push_i.res[1];
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wp_q  <= wp_q + push_i.n;
      rp_q  <= rp_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/command_line_argument_splitter_core.sv
// command-line argument splitter: one character in, character runs and argument ends out
// path: input register, then the split logic writes its words into the result queue
// throughput: one character per cycle while the queue has room; a two-word character
//   needs both words on the single output port, the four-word result queue absorbs bursts
// reset: asynchronous, active low; parse state returns to start of line, queue empties
module command_line_argument_splitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_char_o,
  output logic [11:0] run_length_o,
  output logic        arg_end_o,
  output logic [11:0] arg_count_o,
  output logic        last_result_o
);
  import clas_pkg::*;

  push_t push;
  logic  space;
  res_t  res;

  // parser with input register
  clas_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .space_i     (space),
    .push_o      (push)
  );

  // result queue
  clas_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign out_char_o    = res.out_char;
  assign run_length_o  = res.run_length;
  assign arg_end_o     = res.arg_end;
  assign arg_count_o   = res.arg_count;
  assign last_result_o = res.last_result;

endmodule
